/* src/sensor_scale_moving_average_defines.svh */
`ifndef SENSOR_SCALE_MOVING_AVERAGE_DEFINES_SVH
`define SENSOR_SCALE_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SSMA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SSMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ssma_pkg.sv */
`timescale 1ns / 1ps

package ssma_pkg;

    // window depth, a power of two so the mean is a shift
    localparam int WINDOW_DEPTH = 64;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);

    localparam int READING_W    = 16;
    localparam int VAL_W        = 12;
    localparam int PH_W         = 11;
    localparam int PH_TOTAL_W   = PH_W + IDX_W;
    localparam int TEMP_TOTAL_W = VAL_W + IDX_W;
    localparam int ACC_W        = TEMP_TOTAL_W + 1;

    localparam int RAM_DEPTH    = 2 * WINDOW_DEPTH;
    localparam int RAM_AW       = IDX_W + 1;

    localparam int PH_PROD_W    = 21;
    localparam int TEMP_PROD_W  = 20;
    localparam int PH_SHIFT     = $clog2(512);
    localparam int TEMP_SHIFT   = $clog2(16);

    localparam logic signed [READING_W-1:0] PH_SUM_MIN   = 16'sd0;
    localparam logic signed [READING_W-1:0] PH_SUM_MAX   = 16'sd20460;
    localparam logic signed [READING_W-1:0] TEMP_RAW_MIN = -16'sd880;
    localparam logic signed [READING_W-1:0] TEMP_RAW_MAX = 16'sd2000;
    localparam logic [5:0]                  PH_MULT      = 6'(700 / 20);
    localparam logic signed [TEMP_PROD_W-1:0] TEMP_MULT  = 20'sd10;
    localparam logic signed [TEMP_PROD_W-1:0] TEMP_ROUND = 20'sd15;

    localparam logic CH_PH   = 1'b0;
    localparam logic CH_TEMP = 1'b1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                    channel;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic busy;
        logic issue;
    } back_stat_t;

endpackage

/* src/ssma_ram.sv */
`timescale 1ns / 1ps

module ssma_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/ssma_front.sv */
`timescale 1ns / 1ps

module ssma_front
    import ssma_pkg::*;
(
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic signed [READING_W-1:0] reading,
    input  logic                        queue_full,
    output logic                        push,
    output item_t                       push_item
);

    logic signed [READING_W-1:0]   ph_clamp;
    logic signed [READING_W-1:0]   temp_clamp;
    logic [PH_PROD_W-1:0]          ph_prod;
    logic signed [TEMP_PROD_W-1:0] temp_prod;
    logic signed [TEMP_PROD_W-1:0] temp_adj;
    logic [PH_W-1:0]               ph_scaled;
    logic signed [VAL_W-1:0]       temp_scaled;

    always_comb
    begin
        if (reading < PH_SUM_MIN)
        begin
            ph_clamp = PH_SUM_MIN;
        end
        else if (reading > PH_SUM_MAX)
        begin
            ph_clamp = PH_SUM_MAX;
        end
        else
        begin
            ph_clamp = reading;
        end

        if (reading < TEMP_RAW_MIN)
        begin
            temp_clamp = TEMP_RAW_MIN;
        end
        else if (reading > TEMP_RAW_MAX)
        begin
            temp_clamp = TEMP_RAW_MAX;
        end
        else
        begin
            temp_clamp = reading;
        end
    end

    // sum * 35 / 512, never negative after the clamp
    assign ph_prod   = PH_PROD_W'(unsigned'(ph_clamp)) * PH_PROD_W'(PH_MULT);
    assign ph_scaled = ph_prod[PH_SHIFT +: PH_W];

    // raw * 10 / 16 toward zero: bias negatives before the shift
    assign temp_prod   = TEMP_PROD_W'(temp_clamp) * TEMP_MULT;
    assign temp_adj    = temp_prod + (temp_prod[TEMP_PROD_W-1] ? TEMP_ROUND : '0);
    assign temp_scaled = temp_adj[TEMP_SHIFT +: VAL_W];

    assign in_stall          = queue_full;
    assign push              = in_valid && !queue_full;
    assign push_item.channel = mode;
    assign push_item.value   = (mode == CH_TEMP) ? temp_scaled : VAL_W'(ph_scaled);

endmodule

/* src/ssma_fifo.sv */
`timescale 1ns / 1ps

module ssma_fifo
    import ssma_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  item_t      push_item,
    input  logic       pop,
    output item_t      pop_item,
    output fifo_stat_t stat
);

    item_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item   = entries_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

/* src/ssma_back.sv */
`timescale 1ns / 1ps

module ssma_back
    import ssma_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  item_t                   head_item,
    input  logic                    queue_empty,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    channel,
    output logic signed [VAL_W-1:0] value,
    output logic                    averaged,
    output back_stat_t              stat
);

    logic                           busy_reg;
    logic                           busy_next;
    item_t                          item_reg;
    logic [IDX_W-1:0]               ph_pos_reg;
    logic [IDX_W-1:0]               temp_pos_reg;
    logic                           ph_full_reg;
    logic                           temp_full_reg;
    logic [PH_TOTAL_W-1:0]          ph_total_reg;
    logic signed [TEMP_TOTAL_W-1:0] temp_total_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           channel_reg;
    logic signed [VAL_W-1:0]        value_reg;
    logic                           averaged_reg;

    logic                           issue;
    logic                           complete;
    logic [RAM_AW-1:0]              rd_addr;
    logic [VAL_W-1:0]               rd_data;
    logic [IDX_W-1:0]               pos_cur;
    logic [IDX_W-1:0]               pos_new;
    logic                           full_cur;
    logic                           full_new;
    logic                           wrap;
    logic signed [ACC_W-1:0]        total_cur;
    logic signed [ACC_W-1:0]        old_val;
    logic signed [ACC_W-1:0]        new_val;
    logic signed [ACC_W-1:0]        total_new;
    logic signed [ACC_W-1:0]        mean_adj;
    logic signed [VAL_W-1:0]        mean;

    // one request in flight: read the slot, then write it back
    assign issue    = !busy_reg && !queue_empty;
    assign complete = busy_reg && (!out_valid_reg || !out_stall);
    assign pop      = issue;

    assign rd_addr = {head_item.channel,
                      (head_item.channel == CH_TEMP) ? temp_pos_reg : ph_pos_reg};

    ssma_ram #(
        .WIDTH (VAL_W),
        .DEPTH (RAM_DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (complete),
        .wr_addr ({item_reg.channel, pos_cur}),
        .wr_data (item_reg.value),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (item_reg.channel == CH_TEMP)
        begin
            pos_cur   = temp_pos_reg;
            full_cur  = temp_full_reg;
            total_cur = ACC_W'(temp_total_reg);
        end
        else
        begin
            pos_cur   = ph_pos_reg;
            full_cur  = ph_full_reg;
            total_cur = signed'(ACC_W'(ph_total_reg));
        end
        wrap      = (pos_cur == IDX_W'(WINDOW_DEPTH - 1));
        pos_new   = wrap ? '0 : pos_cur + 1'b1;
        full_new  = full_cur || wrap;
        old_val   = full_cur ? ACC_W'(signed'(rd_data)) : '0;
        new_val   = ACC_W'(item_reg.value);
        total_new = total_cur + new_val - old_val;
        // divide by the depth toward zero
        mean_adj  = total_new
                  + (total_new[ACC_W-1] ? ACC_W'(WINDOW_DEPTH - 1) : ACC_W'(0));
        mean      = mean_adj[IDX_W +: VAL_W];
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (issue)
        begin
            busy_next = 1'b1;
        end
        else if (complete)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (complete)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            ph_pos_reg     <= '0;
            temp_pos_reg   <= '0;
            ph_full_reg    <= 1'b0;
            temp_full_reg  <= 1'b0;
            ph_total_reg   <= '0;
            temp_total_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (complete)
            begin
                if (item_reg.channel == CH_TEMP)
                begin
                    temp_pos_reg   <= pos_new;
                    temp_full_reg  <= full_new;
                    temp_total_reg <= total_new[TEMP_TOTAL_W-1:0];
                end
                else
                begin
                    ph_pos_reg   <= pos_new;
                    ph_full_reg  <= full_new;
                    ph_total_reg <= unsigned'(total_new[PH_TOTAL_W-1:0]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            item_reg <= head_item;
        end
        if (complete)
        begin
            channel_reg  <= item_reg.channel;
            value_reg    <= full_new ? mean : item_reg.value;
            averaged_reg <= full_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign channel    = channel_reg;
    assign value      = value_reg;
    assign averaged   = averaged_reg;
    assign stat.busy  = busy_reg;
    assign stat.issue = issue;

endmodule

/* src/sensor_scale_moving_average.sv */
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// in      | in        | in_valid / in_stall   | mode, reading
// out     | out       | out_valid / out_stall | channel, value, averaged
//
// one request at a time, set by the window memory: read the slot, then write it back before the next is taken
// an accepted reading is registered in the queue, then in the request register, then in the output register
// reset clears window positions, fill flags, totals and the queue; memory is not cleared
// a stalled output holds the back end; the 2-entry queue keeps taking input until full
`include "sensor_scale_moving_average_defines.svh"

module sensor_scale_moving_average
    import ssma_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        mode,
    input  logic signed [READING_W-1:0] reading,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        channel,
    output logic signed [VAL_W-1:0]     value,
    output logic                        averaged
);

    logic       push;
    item_t      push_item;
    logic       pop;
    item_t      head_item;
    fifo_stat_t fifo_stat;
    back_stat_t back_stat;

    ssma_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .reading    (reading),
        .queue_full (fifo_stat.full),
        .push       (push),
        .push_item  (push_item)
    );

    ssma_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (head_item),
        .stat      (fifo_stat)
    );

    ssma_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_item   (head_item),
        .queue_empty (fifo_stat.empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .channel     (channel),
        .value       (value),
        .averaged    (averaged),
        .stat        (back_stat)
    );

    `SSMA_ASSERT_IMPL(a_queue_consistent, fifo_stat.full, !fifo_stat.empty, "queue full and empty")
    `SSMA_ASSERT_NEXT(a_issue_busy, back_stat.issue, back_stat.busy, "issue not in flight")
    `SSMA_ASSERT_IMPL(a_ph_nonneg, out_valid && channel == CH_PH, !value[VAL_W-1], "negative ph")

endmodule
